>>> hdl/tepq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event priority queue package
// Shared types and codes for the event queue, its checker and its testbench.
// ----------------------------------------------------------------------------
package tepq_pkg;

    localparam int EV_W      = 48;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int OCC_W     = 7;

    // Packed so that the time sits in the lowest bits, as on the stream bus.
    typedef struct packed {
        logic [7:0]  ev_node;
        logic [7:0]  ev_type;
        logic [31:0] ev_time;
    } ev_t;

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        DROP_NONE = 2'd0,
        DROP_LATE = 2'd1,
        DROP_FULL = 2'd2
    } drop_t;

    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TYPE = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_POP,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

>>> hdl/tepq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tepq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> hdl/timed_event_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event priority queue
// Event queue sorted by time, then type, held in a circular buffer in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one operation per word: tuser holds the kind (push,
//   pop, search), tdata the event time, type and node. The m_ channel returns
//   one word per operation with the popped or found event (hit flag in
//   tuser), the push outcome and the queue status after the operation.
//   The cfg channel writes the end-time limit and the end event type; it is
//   always ready and should be written only while the queue is idle.
//   Latency depends on occupancy, since the single RAM read port is walked
//   one entry per cycle. A push first shifts entries from the tail down to
//   the insertion slot, a pop reads the head entry, and every operation
//   then walks from the head for the search and tx-start check. One
//   operation is in flight at a time and s_tready is high only when the
//   queue is idle.
//   Reset empties the queue at once (head and count cleared, RAM contents
//   are left as they are) and restores both registers to all ones.
//   A stalled m_ side holds the result; the next operation is taken and
//   processed, and waits for the output register before it completes.
// ----------------------------------------------------------------------------
module timed_event_priority_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // s_tdata: event_time[31:0], ev_type[39:32], node_id[47:40]
    input  wire logic [tepq_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: kind[1:0]
    input  wire logic [1:0]                         s_tuser,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // m_tdata: out_time[31:0], out_type[39:32], out_node[47:40],
    //          dropped[49:48], is_empty[50], occupancy[57:51], tx_start[58]
    output logic [tepq_pkg::OUT_DATA_W-1:0]         m_tdata,
    // m_tuser: hit[0]
    output logic [0:0]                              m_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tepq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tepq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import tepq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
    endfunction

    // Control state
    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [31:0]     limit_reg;
    logic [7:0]      end_type_reg;
    logic [CW-1:0]   iss_cnt_reg, iss_cnt_next;
    logic [CW-1:0]   proc_cnt_reg, proc_cnt_next;
    logic            rd_valid_reg, rd_valid_next;
    logic            srch_pend_reg, srch_pend_next;
    logic            tx_pend_reg, tx_pend_next;
    logic            m_tvalid_reg, m_tvalid_next;

    // Payload
    logic [AW-1:0]   rp_reg, rp_next;
    logic [AW-1:0]   dst_reg, dst_next;
    ev_t             new_ev_reg, new_ev_next;
    ev_t             res_ev_reg, res_ev_next;
    logic            hit_reg, hit_next;
    logic            tx_reg, tx_next;
    drop_t           drop_reg, drop_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic            m_tuser_reg, m_tuser_next;

    // RAM port signals
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    ev_t             ram_wdata;
    logic [EV_W-1:0] ram_rdata_raw;
    ev_t             ram_rdata;

    logic [CW:0]     tail_sum;
    logic [AW-1:0]   tail;
    logic            new_less;
    logic [CW+OCC_W-1:0] occ_ext;

    tepq_ram #(
        .WIDTH (EV_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = ev_t'(ram_rdata_raw);

    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);

    // Ties on time and type place the new event behind the queued one.
    assign new_less = {new_ev_reg.ev_time, new_ev_reg.ev_type} <
                      {ram_rdata.ev_time, ram_rdata.ev_type};

    assign occ_ext = {{OCC_W{1'b0}}, count_reg};

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        logic          sp;
        logic          tp;
        logic [CW-1:0] proc_after;
        logic          place;

        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        iss_cnt_next   = iss_cnt_reg;
        proc_cnt_next  = proc_cnt_reg;
        rd_valid_next  = 1'b0;
        srch_pend_next = srch_pend_reg;
        tx_pend_next   = tx_pend_reg;
        rp_next        = rp_reg;
        dst_next       = dst_reg;
        new_ev_next    = new_ev_reg;
        res_ev_next    = res_ev_reg;
        hit_next       = hit_reg;
        tx_next        = tx_reg;
        drop_next      = drop_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        ram_we    = 1'b0;
        ram_waddr = dst_reg;
        ram_wdata = new_ev_reg;
        ram_re    = 1'b0;
        ram_raddr = rp_reg;

        sp         = srch_pend_reg;
        tp         = tx_pend_reg;
        proc_after = proc_cnt_reg;
        place      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    new_ev_next    = ev_t'(s_tdata);
                    res_ev_next    = '0;
                    hit_next       = 1'b0;
                    drop_next      = DROP_NONE;
                    iss_cnt_next   = '0;
                    proc_cnt_next  = '0;
                    // Default setup for the walk from the head.
                    rp_next        = head_reg;
                    tx_pend_next   = 1'b1;
                    tx_next        = 1'b1;
                    srch_pend_next = 1'b0;
                    state_next     = ST_SCAN;
                    case (kind_t'(s_tuser))
                        KIND_PUSH: begin
                            if (s_tdata[31:0] > limit_reg) begin
                                drop_next = DROP_LATE;
                            end else if (count_reg == CW'(QUEUE_DEPTH)) begin
                                drop_next = DROP_FULL;
                            end else begin
                                rp_next    = ptr_dec(tail);
                                dst_next   = tail;
                                state_next = ST_INSERT;
                            end
                        end
                        KIND_POP: begin
                            if (count_reg != '0) begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                state_next = ST_POP;
                            end
                        end
                        KIND_SEARCH: begin
                            srch_pend_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_INSERT: begin
                // Walk down from the tail, moving each later entry up a slot.
                if (rd_valid_reg) begin
                    if (new_less) begin
                        ram_we        = 1'b1;
                        ram_wdata     = ram_rdata;
                        dst_next      = ptr_dec(dst_reg);
                        proc_cnt_next = proc_cnt_reg + CW'(1);
                    end else begin
                        place = 1'b1;
                    end
                end else if (proc_cnt_reg == count_reg) begin
                    place = 1'b1;
                end
                if (place) begin
                    ram_we        = 1'b1;
                    ram_wdata     = new_ev_reg;
                    count_next    = count_reg + CW'(1);
                    rp_next       = head_reg;
                    iss_cnt_next  = '0;
                    proc_cnt_next = '0;
                    state_next    = ST_SCAN;
                end else if (iss_cnt_reg < count_reg) begin
                    ram_re        = 1'b1;
                    rp_next       = ptr_dec(rp_reg);
                    iss_cnt_next  = iss_cnt_reg + CW'(1);
                    rd_valid_next = 1'b1;
                end
            end

            ST_POP: begin
                res_ev_next   = ram_rdata;
                hit_next      = 1'b1;
                head_next     = ptr_inc(head_reg);
                count_next    = count_reg - CW'(1);
                rp_next       = ptr_inc(head_reg);
                iss_cnt_next  = '0;
                proc_cnt_next = '0;
                state_next    = ST_SCAN;
            end

            ST_SCAN: begin
                if (rd_valid_reg) begin
                    if (sp && (ram_rdata.ev_type == new_ev_reg.ev_type)) begin
                        hit_next    = 1'b1;
                        res_ev_next = ram_rdata;
                        sp          = 1'b0;
                    end
                    if (tp) begin
                        if (ram_rdata.ev_type == end_type_reg) begin
                            tx_next = 1'b1;
                            tp      = 1'b0;
                        end else if (ram_rdata.ev_type < end_type_reg) begin
                            tx_next = 1'b0;
                            tp      = 1'b0;
                        end
                    end
                    proc_after = proc_cnt_reg + CW'(1);
                end
                srch_pend_next = sp;
                tx_pend_next   = tp;
                proc_cnt_next  = proc_after;
                if ((!sp && !tp) || (proc_after == count_reg)) begin
                    state_next = ST_OUT;
                end else if (iss_cnt_reg < count_reg) begin
                    ram_re        = 1'b1;
                    rp_next       = ptr_inc(rp_reg);
                    iss_cnt_next  = iss_cnt_reg + CW'(1);
                    rd_valid_next = 1'b1;
                end
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {5'b0, tx_reg, occ_ext[OCC_W-1:0],
                                     (count_reg == '0), drop_reg, res_ev_reg};
                    m_tuser_next  = hit_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            limit_reg     <= '1;
            end_type_reg  <= '1;
            iss_cnt_reg   <= '0;
            proc_cnt_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            srch_pend_reg <= 1'b0;
            tx_pend_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            iss_cnt_reg   <= iss_cnt_next;
            proc_cnt_reg  <= proc_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            srch_pend_reg <= srch_pend_next;
            tx_pend_reg   <= tx_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_END_TIME: limit_reg    <= cfg_data;
                    CFG_END_TYPE: end_type_reg <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        rp_reg      <= rp_next;
        dst_reg     <= dst_next;
        new_ev_reg  <= new_ev_next;
        res_ev_reg  <= res_ev_next;
        hit_reg     <= hit_next;
        tx_reg      <= tx_next;
        drop_reg    <= drop_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
`default_nettype wire

>>> hdl/tepq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event priority queue checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module tepq_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic [tepq_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [0:0]                     m_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready
);

    import tepq_pkg::*;

    // A stalled word must hold.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Without a hit the event fields are all zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[47:0] == 48'd0)
        else $error("event fields not zero on a miss");

    // A dropped push never returns an event.
    a_drop_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[49:48] != 2'd0) |-> !m_tuser[0])
        else $error("hit reported together with a drop");

    // An empty queue reports zero occupancy and never the unused drop code 3.
    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[50] |-> (m_tdata[57:51] == 7'd0) &&
                                    (m_tdata[49:48] != 2'd3))
        else $error("empty flag and occupancy disagree");

endmodule

bind timed_event_priority_queue tepq_checker u_tepq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

>>> bench/tb_timed_event_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event priority queue testbench
// Streams push, pop, search and no-op words into the queue under random back
// pressure, predicts every result word with a sorted-array copy of the queue
// and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_timed_event_priority_queue;
    import tepq_pkg::*;

    localparam int QDEPTH       = 64;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 2 * QDEPTH + 72;
    localparam int CYCLE_LIMIT  = 1_500_000;

    typedef struct packed {
        kind_t kind;
        ev_t   ev;
    } op_t;

    typedef struct packed {
        logic             hit;
        ev_t              ev;
        drop_t            dropped;
        logic             is_empty;
        logic [OCC_W-1:0] occupancy;
        logic             tx_start;
    } result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predicted queue contents, kept sorted, and the predicted registers.
    ev_t         sched_q [QDEPTH];
    int          sched_cnt = 0;
    logic [31:0] lim_time  = 32'hFFFF_FFFF;
    logic [7:0]  end_type  = 8'hFF;

    op_t     op_backlog[$];
    result_t pending_results[$];
    op_t     cur_op;
    int      issued_ops    = 0;
    int      accepted_ops  = 0;
    int      checked_words = 0;
    int      error_count   = 0;
    int      send_idle_pct = 16;
    int      recv_idle_pct = 59;
    int      hold_req      = 0;
    int      hold_ack      = 0;
    int      hold_left     = 0;
    int      cycle_count   = 0;

    timed_event_priority_queue #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Applies one operation to the predicted queue and returns its result word.
    function automatic result_t schedule_op(op_t op);
        result_t r;
        int      pos;
        int      j;
        bit      done;
        r = '0;
        case (op.kind)
            KIND_PUSH: begin
                if (op.ev.ev_time > lim_time) begin
                    r.dropped = DROP_LATE;
                end else if (sched_cnt >= QDEPTH) begin
                    r.dropped = DROP_FULL;
                end else begin
                    // An event equal in time and type goes behind those already queued.
                    pos = 0;
                    while (pos < sched_cnt && (op.ev.ev_time > sched_q[pos].ev_time ||
                           (op.ev.ev_time == sched_q[pos].ev_time &&
                            op.ev.ev_type >= sched_q[pos].ev_type)))
                        pos++;
                    for (j = sched_cnt; j > pos; j--)
                        sched_q[j] = sched_q[j - 1];
                    sched_q[pos] = op.ev;
                    sched_cnt++;
                end
            end
            KIND_POP: begin
                if (sched_cnt > 0) begin
                    r.hit = 1'b1;
                    r.ev  = sched_q[0];
                    for (j = 1; j < sched_cnt; j++)
                        sched_q[j - 1] = sched_q[j];
                    sched_cnt--;
                end
            end
            KIND_SEARCH: begin
                for (j = 0; j < sched_cnt && !r.hit; j++) begin
                    if (sched_q[j].ev_type == op.ev.ev_type) begin
                        r.hit = 1'b1;
                        r.ev  = sched_q[j];
                    end
                end
            end
            default: ;
        endcase
        r.is_empty  = (sched_cnt == 0);
        r.occupancy = OCC_W'(sched_cnt);
        // Walk from the head; stop at the first end event or the first lower type.
        r.tx_start = 1'b1;
        done = 1'b0;
        for (j = 0; j < sched_cnt && !done; j++) begin
            if (sched_q[j].ev_type == end_type) begin
                done = 1'b1;
            end else if (sched_q[j].ev_type < end_type) begin
                r.tx_start = 1'b0;
                done = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("[%0t] word %0d: %s is %0h, expected %0h",
                 $time, checked_words, what, got, want);
    endtask

    // Driver: offers the next operation word from the backlog.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(schedule_op(cur_op));
                accepted_ops++;
            end
            if (!s_tvalid || s_tready) begin
                if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_op = op_backlog.pop_front();
                    s_tdata  <= cur_op.ev;
                    s_tuser  <= cur_op.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest prediction.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata[47:0], m_tdata[49:48], m_tdata[50],
                       m_tdata[57:51], m_tdata[58]};
                if (pending_results.size() == 0) begin
                    report_mismatch("word with nothing expected", m_tdata, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                    if (got.ev.ev_time !== want.ev.ev_time)
                        report_mismatch("out_time", 64'(got.ev.ev_time),
                                        64'(want.ev.ev_time));
                    if (got.ev.ev_type !== want.ev.ev_type)
                        report_mismatch("out_type", 64'(got.ev.ev_type),
                                        64'(want.ev.ev_type));
                    if (got.ev.ev_node !== want.ev.ev_node)
                        report_mismatch("out_node", 64'(got.ev.ev_node),
                                        64'(want.ev.ev_node));
                    if (got.dropped !== want.dropped)
                        report_mismatch("dropped", 64'(got.dropped), 64'(want.dropped));
                    if (got.is_empty !== want.is_empty)
                        report_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
                    if (got.occupancy !== want.occupancy)
                        report_mismatch("occupancy", 64'(got.occupancy),
                                        64'(want.occupancy));
                    if (got.tx_start !== want.tx_start)
                        report_mismatch("tx_start", 64'(got.tx_start), 64'(want.tx_start));
                end
                checked_words++;
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, so the queue backs up and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_timed_event_priority_queue failed");
            $finish;
        end
    end

    task automatic add_op(kind_t kind, logic [31:0] t, logic [7:0] ty, logic [7:0] nd);
        op_t op;
        op.kind        = kind;
        op.ev.ev_time  = t;
        op.ev.ev_type  = ty;
        op.ev.ev_node  = nd;
        op_backlog.push_back(op);
        issued_ops++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_END_TIME)
            lim_time = value;
        else
            end_type = value[7:0];
    endtask

    task automatic wait_drained();
        while (accepted_ops != issued_ops || pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic queue_random_ops(int count);
        int          mode_left;
        int          push_pct;
        int          pop_pct;
        int          pick;
        kind_t       kind;
        logic [31:0] t;
        logic [7:0]  ty;
        mode_left = 0;
        push_pct  = 45;
        pop_pct   = 35;
        repeat (count) begin
            // Fill, drain and balanced stretches sweep the occupancy from empty to full.
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 150);
                case ($urandom_range(0, 2))
                    0: begin push_pct = 70; pop_pct = 15; end
                    1: begin push_pct = 20; pop_pct = 65; end
                    default: begin push_pct = 45; pop_pct = 35; end
                endcase
            end
            mode_left--;
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
                kind = KIND_PUSH;
            else if (pick < push_pct + pop_pct)
                kind = KIND_POP;
            else if (pick < 97)
                kind = KIND_SEARCH;
            else
                kind = KIND_NOP;
            // Small times give many ties; values around the limit probe the late drop.
            pick = $urandom_range(0, 9);
            if (pick < 4)
                t = $urandom_range(0, 15);
            else if (pick < 6)
                t = lim_time + $urandom_range(0, 4) - 2;
            else if (pick < 8)
                t = $urandom();
            else
                t = $urandom_range(0, 4000);
            pick = $urandom_range(0, 19);
            if (pick < 10)
                ty = 8'($urandom_range(0, 7));
            else if (pick < 13)
                ty = end_type;
            else if (pick == 13)
                ty = end_type + 8'd1;
            else if (pick == 14)
                ty = end_type - 8'd1;
            else
                ty = 8'($urandom_range(0, 255));
            add_op(kind, t, ty, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(CFG_END_TIME, 32'd1000);
        write_reg(CFG_END_TYPE, 32'd4);
        // Empty queue: pop and search miss, and the walk finds nothing.
        add_op(KIND_POP,    32'd0, 8'd0, 8'd0);
        add_op(KIND_SEARCH, 32'd0, 8'd4, 8'd0);
        add_op(KIND_NOP,    32'd0, 8'd0, 8'd0);
        // Time equal to the limit is stored; later times are dropped.
        add_op(KIND_PUSH,   32'd1000, 8'd4, 8'd0);
        add_op(KIND_PUSH,   32'd1001, 8'd4, 8'h55);
        add_op(KIND_PUSH,   32'hFFFF_FFFF, 8'hFF, 8'hFF);
        add_op(KIND_PUSH,   32'd0, 8'hFF, 8'hFF);
        // Three equal events must come back in arrival order.
        add_op(KIND_PUSH,   32'd5, 8'd3, 8'd1);
        add_op(KIND_PUSH,   32'd5, 8'd3, 8'd2);
        add_op(KIND_PUSH,   32'd5, 8'd3, 8'd3);
        add_op(KIND_PUSH,   32'd5, 8'd0, 8'h80);
        add_op(KIND_PUSH,   32'd5, 8'd8, 8'h7F);
        add_op(KIND_SEARCH, 32'd0, 8'd3, 8'd0);
        add_op(KIND_SEARCH, 32'd0, 8'd9, 8'd0);
        add_op(KIND_SEARCH, 32'd0, 8'hFF, 8'd0);
        add_op(KIND_NOP,    32'hFFFF_FFFF, 8'hFF, 8'hFF);
        repeat (8) add_op(KIND_POP, 32'd0, 8'd0, 8'd0);
        wait_drained();

        write_reg(CFG_END_TIME, 32'hFFFF_FFFF);
        write_reg(CFG_END_TYPE, 32'd255);
        send_idle_pct = 16;
        recv_idle_pct = 59;
        hold_req++;
        queue_random_ops(600);
        wait_drained();

        // Lowering the limit keeps whatever is already queued above it.
        write_reg(CFG_END_TIME, 32'h8000_0000);
        write_reg(CFG_END_TYPE, 32'd4);
        send_idle_pct = 59;
        recv_idle_pct = 16;
        queue_random_ops(550);
        wait_drained();

        write_reg(CFG_END_TIME, 32'd0);
        write_reg(CFG_END_TYPE, 32'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_ops(100);
        wait_drained();

        write_reg(CFG_END_TIME, 32'd3000);
        write_reg(CFG_END_TYPE, 32'd6);
        hold_req++;
        queue_random_ops(450);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_timed_event_priority_queue passed");
        end else begin
            $display("tb_timed_event_priority_queue failed");
        end
        $finish;
    end

endmodule
